// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on aclk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/ptcs_pkg.sv =====
package ptcs_pkg;

    localparam int DEF_MAX_STEPS = 4;
    localparam int NUM_CUES      = 12;

    localparam logic [1:0] REQ_FRAME   = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_SILENCE = 2'd2;

    localparam logic [1:0] CH_CUE   = 2'd0;
    localparam logic [1:0] CH_DRONE = 2'd1;
    localparam logic [1:0] CH_NOISE = 2'd2;

    localparam logic [1:0] CMD_ATTACK  = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_FREQ    = 2'd2;

    localparam logic [1:0] REG_ENABLED     = 2'd0;
    localparam logic [1:0] REG_DRONE_BASE  = 2'd1;
    localparam logic [1:0] REG_DRONE_SLOPE = 2'd2;
    localparam logic [1:0] REG_NOISE_FREQ  = 2'd3;

    localparam logic        RST_ENABLED     = 1'b1;
    localparam logic [10:0] RST_DRONE_BASE  = 11'd420;
    localparam logic [2:0]  RST_DRONE_SLOPE = 3'd2;
    localparam logic [11:0] RST_NOISE_FREQ  = 12'd900;

    typedef struct packed {
        logic [11:0] freq;
        logic [4:0]  ticks;
    } step_t;

    typedef struct packed {
        logic [11:0] frequency;
        logic [1:0]  command;
        logic [1:0]  channel;
        logic        last;
    } cmd_t;

    localparam step_t CUE_ROM [0:15][0:3] = '{
        '{'{12'd620, 5'd6},  '{12'd500, 5'd10}, '{12'd410, 5'd22},  '{12'd0, 5'd0}},
        '{'{12'd523, 5'd5},  '{12'd659, 5'd5},  '{12'd784, 5'd5},   '{12'd1046, 5'd22}},
        '{'{12'd660, 5'd4},  '{12'd500, 5'd9},  '{12'd430, 5'd13},  '{12'd0, 5'd0}},
        '{'{12'd600, 5'd4},  '{12'd440, 5'd14}, '{12'd0, 5'd0},     '{12'd0, 5'd0}},
        '{'{12'd1320, 5'd18}, '{12'd0, 5'd0},   '{12'd0, 5'd0},     '{12'd0, 5'd0}},
        '{'{12'd784, 5'd5},  '{12'd1046, 5'd12}, '{12'd0, 5'd0},    '{12'd0, 5'd0}},
        '{'{12'd440, 5'd3},  '{12'd880, 5'd4},  '{12'd1320, 5'd10}, '{12'd0, 5'd0}},
        '{'{12'd520, 5'd3},  '{12'd880, 5'd10}, '{12'd0, 5'd0},     '{12'd0, 5'd0}},
        '{'{12'd660, 5'd7},  '{12'd0, 5'd0},    '{12'd0, 5'd0},     '{12'd0, 5'd0}},
        '{'{12'd440, 5'd11}, '{12'd0, 5'd0},    '{12'd0, 5'd0},     '{12'd0, 5'd0}},
        '{'{12'd580, 5'd3},  '{12'd460, 5'd6},  '{12'd0, 5'd0},     '{12'd0, 5'd0}},
        '{'{12'd540, 5'd5},  '{12'd0, 5'd0},    '{12'd0, 5'd0},     '{12'd0, 5'd0}},
        '{'{12'd0, 5'd0},    '{12'd0, 5'd0},    '{12'd0, 5'd0},     '{12'd0, 5'd0}},
        '{'{12'd0, 5'd0},    '{12'd0, 5'd0},    '{12'd0, 5'd0},     '{12'd0, 5'd0}},
        '{'{12'd0, 5'd0},    '{12'd0, 5'd0},    '{12'd0, 5'd0},     '{12'd0, 5'd0}},
        '{'{12'd0, 5'd0},    '{12'd0, 5'd0},    '{12'd0, 5'd0},     '{12'd0, 5'd0}}
    };

    localparam logic [2:0] CUE_LEN [0:15] = '{
        3'd3, 3'd4, 3'd3, 3'd2, 3'd1, 3'd2, 3'd3, 3'd2, 3'd1, 3'd1, 3'd2, 3'd1,
        3'd0, 3'd0, 3'd0, 3'd0
    };

endpackage

// ===== rtl/priority_tone_cue_sequencer_unit.sv =====
// Channel | Dir | Signals                         | Contents
// s_      | in  | s_tvalid s_tready s_tdata s_tuser | one request per accept
// m_      | out | m_tvalid m_tready m_tdata m_tlast | one command per accept
// apb     | in  | psel penable pwrite paddr pwdata  | four config registers
//
// A request waits in the input register, then its 0 to 3 commands load the
// command register once the previous group is empty or its last command is taken.
// The commands drain on m_ one a cycle while m_tready is high.
// A new request is taken while commands still wait; only a full input register
// with an undrained command group stalls s_. aresetn is synchronous, active low.
`include "assert_macros.svh"

module priority_tone_cue_sequencer_unit
    import ptcs_pkg::*;
#(
    parameter int MAX_STEPS = DEF_MAX_STEPS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // rev[7:0], grinding[8], cue_events[20:9], zero pad
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // channel[1:0], command[3:2], frequency[15:4]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = $clog2(MAX_STEPS + 1);
    localparam int CW = (PW > 3) ? PW : 3;

    logic        enabled_reg;
    logic [10:0] drone_base_reg;
    logic [2:0]  drone_slope_reg;
    logic [11:0] noise_freq_reg;

    logic        in_vld_reg;
    logic [1:0]  in_req_reg;
    logic [7:0]  in_rev_reg;
    logic        in_grind_reg;
    logic [11:0] in_ev_reg;

    logic [3:0]    cue_reg, cue_next;
    logic [2:0]    step_total_reg, step_total_next;
    logic [PW-1:0] step_pos_reg, step_pos_next;
    logic [4:0]    ticks_reg, ticks_next;
    logic          drone_on_reg, drone_on_next;
    logic          noise_on_reg, noise_on_next;

    cmd_t       grp_reg [3];
    cmd_t       grp_next [3];
    logic [1:0] grp_cnt_reg;
    logic [1:0] grp_cnt_next;

    logic        fire;
    logic        cfg_wr;
    logic [11:0] drone_freq;
    logic [3:0]  top_cue;
    logic [2:0]  load_len;
    logic        step_left;
    step_t       cur_step;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_ENABLED:     prdata = {31'd0, enabled_reg};
            REG_DRONE_BASE:  prdata = {21'd0, drone_base_reg};
            REG_DRONE_SLOPE: prdata = {29'd0, drone_slope_reg};
            REG_NOISE_FREQ:  prdata = {20'd0, noise_freq_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg     <= RST_ENABLED;
            drone_base_reg  <= RST_DRONE_BASE;
            drone_slope_reg <= RST_DRONE_SLOPE;
            noise_freq_reg  <= RST_NOISE_FREQ;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ENABLED:     enabled_reg     <= pwdata[0];
                REG_DRONE_BASE:  drone_base_reg  <= pwdata[10:0];
                REG_DRONE_SLOPE: drone_slope_reg <= pwdata[2:0];
                REG_NOISE_FREQ:  noise_freq_reg  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    assign fire     = in_vld_reg && ((grp_cnt_reg == 2'd0) || (grp_cnt_reg == 2'd1 && m_tready));
    assign s_tready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg   <= s_tuser;
            in_rev_reg   <= s_tdata[7:0];
            in_grind_reg <= s_tdata[8];
            in_ev_reg    <= s_tdata[20:9];
        end
    end

    always_comb begin
        top_cue = 4'd0;
        for (int i = NUM_CUES - 1; i >= 0; i--) begin
            if (in_ev_reg[i]) begin
                top_cue = 4'(i);
            end
        end
    end

    assign load_len   = (CW'(CUE_LEN[top_cue]) > CW'(MAX_STEPS)) ? 3'(MAX_STEPS)
                                                                 : CUE_LEN[top_cue];
    assign drone_freq = 12'(drone_base_reg) + 12'(drone_slope_reg) * 12'(in_rev_reg);
    assign step_left  = CW'(step_pos_reg) < CW'(step_total_reg);
    assign cur_step   = CUE_ROM[cue_reg][2'(step_pos_reg)];

    always_comb begin
        cue_next        = cue_reg;
        step_total_next = step_total_reg;
        step_pos_next   = step_pos_reg;
        ticks_next      = ticks_reg;
        drone_on_next   = drone_on_reg;
        noise_on_next   = noise_on_reg;
        grp_cnt_next    = 2'd0;
        for (int i = 0; i < 3; i++) begin
            grp_next[i] = '0;
        end
        case (in_req_reg)
            REQ_FRAME: begin
                if (enabled_reg) begin
                    if (in_rev_reg != 8'd0) begin
                        grp_next[grp_cnt_next] = '{drone_freq,
                                                   drone_on_reg ? CMD_FREQ : CMD_ATTACK,
                                                   CH_DRONE, 1'b0};
                        grp_cnt_next  = grp_cnt_next + 2'd1;
                        drone_on_next = 1'b1;
                    end else if (drone_on_reg) begin
                        grp_next[grp_cnt_next] = '{12'd0, CMD_RELEASE, CH_DRONE, 1'b0};
                        grp_cnt_next  = grp_cnt_next + 2'd1;
                        drone_on_next = 1'b0;
                    end
                    if (in_grind_reg) begin
                        if (!noise_on_reg) begin
                            grp_next[grp_cnt_next] = '{noise_freq_reg, CMD_ATTACK, CH_NOISE, 1'b0};
                            grp_cnt_next  = grp_cnt_next + 2'd1;
                            noise_on_next = 1'b1;
                        end
                    end else if (noise_on_reg) begin
                        grp_next[grp_cnt_next] = '{12'd0, CMD_RELEASE, CH_NOISE, 1'b0};
                        grp_cnt_next  = grp_cnt_next + 2'd1;
                        noise_on_next = 1'b0;
                    end
                    if (in_ev_reg != 12'd0) begin
                        cue_next        = top_cue;
                        step_total_next = load_len;
                        step_pos_next   = '0;
                        ticks_next      = 5'd0;
                        if (in_ev_reg[0]) begin
                            grp_next[grp_cnt_next] = '{12'd0, CMD_RELEASE, CH_DRONE, 1'b0};
                            grp_cnt_next  = grp_cnt_next + 2'd1;
                            drone_on_next = 1'b0;
                        end
                    end
                end
            end
            REQ_TICK: begin
                if (ticks_reg != 5'd0) begin
                    ticks_next = ticks_reg - 5'd1;
                end else if (step_left && CW'(step_pos_reg) < CW'(MAX_STEPS)) begin
                    grp_next[0]   = '{cur_step.freq, CMD_ATTACK, CH_CUE, 1'b0};
                    grp_cnt_next  = 2'd1;
                    ticks_next    = cur_step.ticks;
                    step_pos_next = step_pos_reg + PW'(1);
                end else begin
                    if (CW'(step_pos_reg) < CW'(MAX_STEPS)) begin
                        step_pos_next = step_pos_reg + PW'(1);
                    end
                    if (step_total_reg != 3'd0) begin
                        grp_next[0]     = '{12'd0, CMD_RELEASE, CH_CUE, 1'b0};
                        grp_cnt_next    = 2'd1;
                        step_total_next = 3'd0;
                    end
                end
            end
            REQ_SILENCE: begin
                grp_next[0]     = '{12'd0, CMD_RELEASE, CH_CUE, 1'b0};
                grp_next[1]     = '{12'd0, CMD_RELEASE, CH_DRONE, 1'b0};
                grp_next[2]     = '{12'd0, CMD_RELEASE, CH_NOISE, 1'b0};
                grp_cnt_next    = 2'd3;
                step_total_next = 3'd0;
                drone_on_next   = 1'b0;
                noise_on_next   = 1'b0;
            end
            default: ;
        endcase
        for (int i = 0; i < 3; i++) begin
            grp_next[i].last = (grp_cnt_next != 2'd0) && (2'(i) == grp_cnt_next - 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_total_reg <= 3'd0;
            step_pos_reg   <= '0;
            ticks_reg      <= 5'd0;
            drone_on_reg   <= 1'b0;
            noise_on_reg   <= 1'b0;
        end else if (fire) begin
            step_total_reg <= step_total_next;
            step_pos_reg   <= step_pos_next;
            ticks_reg      <= ticks_next;
            drone_on_reg   <= drone_on_next;
            noise_on_reg   <= noise_on_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            cue_reg <= cue_next;
        end
    end

    // load a fresh group, else shift out the taken command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_cnt_reg <= 2'd0;
        end else if (fire) begin
            grp_cnt_reg <= grp_cnt_next;
        end else if (m_tvalid && m_tready) begin
            grp_cnt_reg <= grp_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            grp_reg <= grp_next;
        end else if (m_tvalid && m_tready) begin
            grp_reg[0] <= grp_reg[1];
            grp_reg[1] <= grp_reg[2];
        end
    end

    assign m_tvalid = grp_cnt_reg != 2'd0;
    assign m_tdata  = {grp_reg[0].frequency, grp_reg[0].command, grp_reg[0].channel};
    assign m_tlast  = grp_reg[0].last;

    `CHK_IMPLY(a_last_on_final, m_tvalid && m_tlast, grp_cnt_reg == 2'd1)
    `CHK_IMPLY(a_more_after, m_tvalid && !m_tlast, grp_cnt_reg != 2'd1)
    `CHK_IMPLY(a_pos_bound, 1'b1, CW'(step_pos_reg) <= CW'(MAX_STEPS))
    `CHK_NEXT(a_silence_clears, fire && in_req_reg == REQ_SILENCE,
              step_total_reg == 3'd0 && !drone_on_reg && !noise_on_reg)

endmodule
